FILE: design/mba_pkg.sv
// Package with shared constants and types for the mouse button autofire block.
package mba_pkg;

  // Number of clickers; clicker i serves button bit i.
  localparam int CLICKER_COUNT = 2;
  // Width of the tick counters.
  localparam int TIME_BITS = 20;

  // Widths of the channel fields and the configuration port.
  localparam int BUTTON_BITS = 8;
  localparam int CFG_BITS = 20;
  localparam int CFG_INDEX_BITS = 1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_HALF_INTERVAL = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RECENT_WINDOW = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [CFG_BITS-1:0] HALF_INTERVAL_RESET = 20'd31250;
  localparam logic [CFG_BITS-1:0] RECENT_WINDOW_RESET = 20'd62500;

  // Input command codes.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_BUTTONS = 1'b1;

  // Reports that one tick can produce, and the output queue size.
  localparam int MAX_RESULTS = 2;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int COUNT_BITS = $clog2(FIFO_DEPTH + 1);

  // One queued report.
  typedef struct packed {
    logic [BUTTON_BITS-1:0] buttons;
    logic                   clicker;
    logic                   last;
  } report_t;

endpackage

FILE: design/mba_in_if.sv
// Input channel interface: ticks and physical button reports.
interface mba_in_if;
  import mba_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   command;
  logic [BUTTON_BITS-1:0] button_bits;

  modport source (output valid, output command, output button_bits, input ready);
  modport sink (input valid, input command, input button_bits, output ready);
endinterface

FILE: design/mba_out_if.sv
// Output channel interface: generated mouse reports.
interface mba_out_if;
  import mba_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [BUTTON_BITS-1:0] report_buttons;
  logic                   clicker_index;
  logic                   last_of_run;

  modport source (output valid, output report_buttons, output clicker_index,
                  output last_of_run, input ready);
  modport sink (input valid, input report_buttons, input clicker_index,
                input last_of_run, output ready);
endinterface

FILE: design/mouse_button_autofire_top.sv
// Top level of the mouse button autofire block.
//
// Usage: in_ch carries one item per transfer, either a time tick
// (command = 0) or a physical button report (command = 1, button_bits).
// A button report updates the held marks and recent windows and produces
// no output. A tick advances every clicker; each clicker whose timer
// expires and keeps firing sends one report on out_ch, left before right,
// with last_of_run set on the final report of that tick.
// The reports of a tick are registered into the output queue when the
// tick's transfer is accepted. Throughput: one input item per cycle while
// in_ch.ready is high; the state update is a single registered pass.
// Reports leave through a four-entry queue at one per cycle unless out_ch
// stalls; in_ch.ready is low while fewer than two entries are free, so a
// stalled receiver back-pressures the input once three or four are queued.
// Reset (rst, synchronous) clears all clicker state and the queue and loads
// half_interval = 31250 and recent_window = 62500. The user must write the
// registers via cfg_write, cfg_index, cfg_data only while idle (not enforced).
module mouse_button_autofire_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [mba_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [mba_pkg::CFG_BITS-1:0]    cfg_data,
  mba_in_if.sink                          in_ch,
  mba_out_if.source                       out_ch
);
  import mba_pkg::*;

  // Configuration registers.
  logic [CFG_BITS-1:0] half_interval;
  logic [CFG_BITS-1:0] recent_window;

  // Clicker state.
  logic [BUTTON_BITS-1:0]   last_bits, last_bits_next;
  logic [CLICKER_COUNT-1:0] held, held_next;
  logic [CLICKER_COUNT-1:0] level, level_next;
  logic [CLICKER_COUNT-1:0] armed, armed_next;
  logic [TIME_BITS-1:0]     timer_rem [CLICKER_COUNT];
  logic [TIME_BITS-1:0]     timer_rem_next [CLICKER_COUNT];
  logic [TIME_BITS-1:0]     window_rem [CLICKER_COUNT];
  logic [TIME_BITS-1:0]     window_rem_next [CLICKER_COUNT];

  // Per-clicker report requests of the current tick.
  logic [CLICKER_COUNT-1:0] emit;
  logic [BUTTON_BITS-1:0]   emit_bits [CLICKER_COUNT];

  // Output queue.
  report_t               fifo [FIFO_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr, rd_ptr;
  logic [COUNT_BITS-1:0] count, count_next;
  logic [1:0]            push_n;
  report_t               entry0, entry1;
  logic                  in_fire, out_fire;

  logic [TIME_BITS-1:0] half_load, window_load;

  assign half_load   = TIME_BITS'(half_interval);
  assign window_load = TIME_BITS'(recent_window);

  assign in_ch.ready = (count <= COUNT_BITS'(FIFO_DEPTH - MAX_RESULTS));
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;

  // Configuration writes; out-of-range indexes cannot occur at this width.
  always_ff @(posedge clk) begin
    if (rst) begin
      half_interval <= HALF_INTERVAL_RESET;
      recent_window <= RECENT_WINDOW_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_HALF_INTERVAL: half_interval <= cfg_data;
        REG_RECENT_WINDOW: recent_window <= cfg_data;
      endcase
    end
  end

  // Next state of every clicker for the accepted item.
  always_comb begin
    logic                 was_on, is_on;
    logic [TIME_BITS-1:0] w_dec, t_dec;
    was_on = 1'b0;
    is_on  = 1'b0;
    w_dec  = '0;
    t_dec  = '0;
    last_bits_next = last_bits;
    held_next  = held;
    level_next = level;
    armed_next = armed;
    timer_rem_next  = timer_rem;
    window_rem_next = window_rem;
    emit = '0;
    for (int i = 0; i < CLICKER_COUNT; i++) begin
      emit_bits[i] = last_bits;
    end
    if (in_fire) begin
      if (in_ch.command == CMD_BUTTONS) begin
        // Button report: detect press and release edges.
        for (int i = 0; i < CLICKER_COUNT; i++) begin
          was_on = last_bits[i];
          is_on  = in_ch.button_bits[i];
          if (!was_on && is_on) begin
            held_next[i]       = 1'b1;
            level_next[i]      = 1'b1;
            window_rem_next[i] = window_load;
            if (!armed[i]) begin
              armed_next[i]     = 1'b1;
              timer_rem_next[i] = half_load;
            end
          end else if (was_on && !is_on) begin
            held_next[i]       = 1'b0;
            window_rem_next[i] = window_load;
          end
        end
        last_bits_next = in_ch.button_bits;
      end else begin
        // Tick: count down windows and armed timers, handle expiries.
        for (int i = 0; i < CLICKER_COUNT; i++) begin
          w_dec = (window_rem[i] != '0) ? window_rem[i] - 1'b1 : window_rem[i];
          t_dec = (timer_rem[i] != '0) ? timer_rem[i] - 1'b1 : timer_rem[i];
          window_rem_next[i] = w_dec;
          if (armed[i]) begin
            timer_rem_next[i] = t_dec;
            if (t_dec == '0) begin
              if (!held[i] && w_dec == '0) begin
                // Idle and window lapsed: the clicker stops.
                armed_next[i] = 1'b0;
                held_next[i]  = 1'b0;
                level_next[i] = 1'b0;
              end else begin
                // Toggle, report and re-arm.
                level_next[i]     = !level[i];
                emit[i]           = 1'b1;
                emit_bits[i][i]   = !level[i];
                timer_rem_next[i] = half_load;
              end
            end
          end
        end
      end
    end
  end

  // Pick the first two reporting clickers, lowest index first.
  always_comb begin
    entry0 = '0;
    entry1 = '0;
    push_n = 2'd0;
    for (int i = 0; i < CLICKER_COUNT; i++) begin
      if (emit[i]) begin
        if (push_n == 2'd0) begin
          entry0.buttons = emit_bits[i];
          entry0.clicker = 1'(i);
          push_n = 2'd1;
        end else if (push_n == 2'd1) begin
          entry1.buttons = emit_bits[i];
          entry1.clicker = 1'(i);
          push_n = 2'd2;
        end
      end
    end
    entry0.last = (push_n == 2'd1);
    entry1.last = 1'b1;
  end

  assign count_next = count + COUNT_BITS'(push_n) - COUNT_BITS'(out_fire);

  // Clicker state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_bits <= '0;
      held  <= '0;
      level <= '0;
      armed <= '0;
      for (int i = 0; i < CLICKER_COUNT; i++) begin
        timer_rem[i]  <= '0;
        window_rem[i] <= '0;
      end
    end else begin
      last_bits <= last_bits_next;
      held  <= held_next;
      level <= level_next;
      armed <= armed_next;
      timer_rem  <= timer_rem_next;
      window_rem <= window_rem_next;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_BITS'(push_n);
      if (out_fire) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo[wr_ptr] <= entry0;
    end
    if (push_n == 2'd2) begin
      fifo[wr_ptr + 1'b1] <= entry1;
    end
  end

  // Head of the queue drives the output transfer.
  assign out_ch.valid          = (count != '0);
  assign out_ch.report_buttons = fifo[rd_ptr].buttons;
  assign out_ch.clicker_index  = fifo[rd_ptr].clicker;
  assign out_ch.last_of_run    = fifo[rd_ptr].last;

`ifndef SYNTH
  // The fill count never passes the queue size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_BITS'(FIFO_DEPTH))
    else $error("report queue overflow");

  // A button report never adds entries to the queue.
  a_buttons_no_push: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_ch.command == CMD_BUTTONS) |=> count <= $past(count))
    else $error("button report produced a queued report");

  // A report that is not the last of its tick has its partner queued behind it.
  a_pair_queued: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.last_of_run) |-> count >= COUNT_BITS'(2))
    else $error("first report of a pair queued alone");

  // A held or pressed clicker always has its timer running.
  for (genvar g = 0; g < CLICKER_COUNT; g++) begin : g_chk
    a_active_armed: assert property (@(posedge clk) disable iff (rst)
      (held[g] || level[g]) |-> armed[g])
      else $error("active clicker without running timer");
  end
`endif

endmodule
